/* hw/rtl/tlp_pkg.sv */
// ----------------------------------------------------------------------------
// tlp_pkg
// Types and constants shared by the tile layer placement block.
// ----------------------------------------------------------------------------
package tlp_pkg;

    localparam int REG_INDEX_W = 3;
    localparam int REG_DATA_W  = 16;

    // register indexes on the configuration port
    localparam logic [REG_INDEX_W-1:0] REG_VIDEO_CONTROL  = 3'd0;
    localparam logic [REG_INDEX_W-1:0] REG_SCROLL_X_P0    = 3'd1;
    localparam logic [REG_INDEX_W-1:0] REG_SCROLL_Y_P0    = 3'd2;
    localparam logic [REG_INDEX_W-1:0] REG_SCROLL_X_P1    = 3'd3;
    localparam logic [REG_INDEX_W-1:0] REG_SCROLL_Y_P1    = 3'd4;
    localparam logic [REG_INDEX_W-1:0] REG_BANK_NIBBLES   = 3'd5;
    localparam logic [REG_INDEX_W-1:0] REG_CUSTOM_BANKING = 3'd6;

    // video_control bits
    localparam int VC_FLIP_Y      = 0;
    localparam int VC_FLIP_X      = 1;
    localparam int VC_PLANE_ORDER = 3;
    localparam int VC_TILE_FLIP_Y = 5;

    // placement constants, all but the colour base on the 9-bit wrapped position
    localparam logic [8:0] CELL_FLIP_BASE  = 9'd504;   // 63*8
    localparam logic [8:0] SCROLL_FLIP_X   = 9'd192;   // 256 - 64
    localparam logic [8:0] SCROLL_FLIP_Y   = 9'd256;
    localparam logic [8:0] X_RESIGN_LIMIT  = 9'd320;
    localparam logic [8:0] X_LEFT_WRAPPED  = 9'd504;   // -8 after re-signing
    localparam logic [8:0] Y_TOP_LIMIT     = 9'd8;
    localparam logic [8:0] Y_BOTTOM_LIMIT  = 9'd240;   // 256 - 16
    localparam logic [1:0] COLOUR_BASE_HI  = 2'b10;    // 0x20 in bits 5:4

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    typedef struct packed {
        logic [15:0] video_control;
        logic [15:0] scroll_x_plane0;
        logic [15:0] scroll_y_plane0;
        logic [15:0] scroll_x_plane1;
        logic [15:0] scroll_y_plane1;
        logic [15:0] bank_nibbles;
        logic        custom_banking;
    } cfg_t;

    typedef struct packed {
        logic [11:0] tile_index;
        logic [15:0] code_plane0;
        logic [15:0] code_plane1;
        logic        opaque_pass;
    } item_t;

    typedef struct packed {
        logic              visible;
        logic signed [9:0] screen_x;
        logic signed [8:0] screen_y;
        logic [18:0]       gfx_address;
        logic [5:0]        colour_group;
        logic              plane_used;
        logic              mirror_x;
        logic              mirror_y;
        logic              transparent;
    } result_t;

endpackage

/* hw/rtl/tlp_place.sv */
// ----------------------------------------------------------------------------
// tlp_place
// Placement logic for one tile: plane select, flips, wrap, clip, gfx address.
// ----------------------------------------------------------------------------
module tlp_place
(
    input  tlp_pkg::cfg_t    cfg,
    input  tlp_pkg::item_t   item,
    output tlp_pkg::result_t res
);

    logic        flip_x;
    logic        flip_y;
    logic        plane;
    logic [15:0] code;
    logic [8:0]  dx;
    logic [8:0]  dy;
    logic [8:0]  sx;
    logic [8:0]  sy;
    logic [8:0]  ux;
    logic [8:0]  uy;
    logic [1:0]  bank;
    logic [3:0]  gbank;
    logic        vis_x;
    logic        vis_y;

    always_comb
    begin
        flip_x = cfg.video_control[tlp_pkg::VC_FLIP_X];
        flip_y = cfg.video_control[tlp_pkg::VC_FLIP_Y];
        plane  = cfg.video_control[tlp_pkg::VC_PLANE_ORDER] ^ item.opaque_pass;
        code   = plane ? item.code_plane1 : item.code_plane0;
        dx     = plane ? cfg.scroll_x_plane1[8:0] : cfg.scroll_x_plane0[8:0];
        dy     = plane ? cfg.scroll_y_plane1[8:0] : cfg.scroll_y_plane0[8:0];
        sx     = {item.tile_index[5:0], 3'b000};
        sy     = {item.tile_index[11:6], 3'b000};

        // screen flips mirror both the cell and the scroll, mod 512
        if (flip_x)
        begin
            dx = tlp_pkg::SCROLL_FLIP_X - dx;
            sx = tlp_pkg::CELL_FLIP_BASE - sx;
        end
        if (flip_y)
        begin
            dy = tlp_pkg::SCROLL_FLIP_Y - dy;
            sy = tlp_pkg::CELL_FLIP_BASE - sy;
        end

        ux = sx - dx;
        uy = sy - dy;

        // x re-signs at 320, y at 256 (sign is simply bit 8)
        vis_x = (ux < tlp_pkg::X_RESIGN_LIMIT) || (ux > tlp_pkg::X_LEFT_WRAPPED);
        vis_y = !uy[8] && (uy > tlp_pkg::Y_TOP_LIMIT) && (uy < tlp_pkg::Y_BOTTOM_LIMIT);

        bank  = code[12:11];
        gbank = cfg.custom_banking ? cfg.bank_nibbles[{bank, 2'b00} +: 4] : {2'b00, bank};

        res.visible      = vis_x && vis_y;
        res.screen_x     = {(ux >= tlp_pkg::X_RESIGN_LIMIT), ux};
        res.screen_y     = uy;
        res.gfx_address  = {gbank, code[10:0], 4'b0000};
        res.colour_group = {tlp_pkg::COLOUR_BASE_HI, plane, code[15:13]};
        res.plane_used   = plane;
        res.mirror_x     = flip_x;
        res.mirror_y     = cfg.video_control[tlp_pkg::VC_TILE_FLIP_Y] ^ flip_y;
        res.transparent  = !item.opaque_pass;
    end

endmodule

/* hw/rtl/tile_layer_placement.sv */
// ----------------------------------------------------------------------------
// tile_layer_placement
// Places one 8x8 cell of a 64x64 scrolling tilemap for the current pass.
// ----------------------------------------------------------------------------
// One item in, one result out, one item per clock while results are taken.
// The item is captured in an input register, the placement logic runs in a
// single combinational pass, and the result lands in the output register.
// The output register moves when free or being taken, the input register
// with it or when empty; back-pressure stalls the stream once both are full.
// Configuration registers are read live by the placement logic; write them
// only while no item is in flight.
module tile_layer_placement
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_wen,
    input  logic [tlp_pkg::REG_INDEX_W-1:0]     cfg_index,
    input  logic [tlp_pkg::REG_DATA_W-1:0]      cfg_data,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tile_index[11:0], code_plane0[27:12], code_plane1[43:28], zero fill
    input  logic [tlp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // opaque_pass
    input  logic                                s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // visible[0], screen_x[10:1], screen_y[19:11], gfx_address[38:20],
    // colour_group[44:39], mirror_x[45], mirror_y[46], transparent[47]
    output logic [tlp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // plane_used
    output logic                                m_axis_tuser
);

    tlp_pkg::cfg_t    cfg_reg;
    tlp_pkg::item_t   item_reg;
    tlp_pkg::result_t res_next;
    tlp_pkg::result_t res_reg;
    logic             item_valid_reg;
    logic             res_valid_reg;
    logic             advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                tlp_pkg::REG_VIDEO_CONTROL:  cfg_reg.video_control   <= cfg_data;
                tlp_pkg::REG_SCROLL_X_P0:    cfg_reg.scroll_x_plane0 <= cfg_data;
                tlp_pkg::REG_SCROLL_Y_P0:    cfg_reg.scroll_y_plane0 <= cfg_data;
                tlp_pkg::REG_SCROLL_X_P1:    cfg_reg.scroll_x_plane1 <= cfg_data;
                tlp_pkg::REG_SCROLL_Y_P1:    cfg_reg.scroll_y_plane1 <= cfg_data;
                tlp_pkg::REG_BANK_NIBBLES:   cfg_reg.bank_nibbles    <= cfg_data;
                tlp_pkg::REG_CUSTOM_BANKING: cfg_reg.custom_banking  <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // whole pipe moves when the output register is empty or being drained; the input register also fills when empty
    assign advance       = !res_valid_reg || m_axis_tready;
    assign s_axis_tready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                item_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                res_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.tile_index  <= s_axis_tdata[11:0];
            item_reg.code_plane0 <= s_axis_tdata[27:12];
            item_reg.code_plane1 <= s_axis_tdata[43:28];
            item_reg.opaque_pass <= s_axis_tuser;
        end
        if (advance && item_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    tlp_place u_place
    (
        .cfg  (cfg_reg),
        .item (item_reg),
        .res  (res_next)
    );

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tuser  = res_reg.plane_used;
    assign m_axis_tdata  = {res_reg.transparent, res_reg.mirror_y, res_reg.mirror_x,
                            res_reg.colour_group, res_reg.gfx_address,
                            res_reg.screen_y, res_reg.screen_x, res_reg.visible};

    // an accepted item is always held in the input register next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> item_valid_reg)
        else $error("accepted item lost before placement");

    // a held item reaches the output when the pipe moves
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && advance |=> res_valid_reg)
        else $error("placed item did not reach output register");

    // palette group carries the plane it was drawn from
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[44:43] == tlp_pkg::COLOUR_BASE_HI)
                          && (m_axis_tdata[42] == m_axis_tuser))
        else $error("colour group does not match plane");

    // a visible tile never has a negative top row
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[19])
        else $error("visible tile above the window");

endmodule

/* bench/tile_layer_placement_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_layer_placement_test
// Self-checking bench for the tile layer placement block. Tiles go in on the
// slave stream and placed results come back on the master stream. A predictor
// in the scoreboard works out each placement from its own copy of the
// registers and checks every result field in order. A short directed part
// comes first, then random register settings with random tiles. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tile_layer_placement_test;

    localparam logic [tlp_pkg::REG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int          NUM_REGS       = 7;
    localparam int          DIRECTED_TILES = 8;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          TILES_PER_PHASE = 50;
    localparam int          HOLD_CYCLES    = 300;
    localparam int unsigned LIMIT_CYCLES   = 200000;

    class placement_scoreboard;
        tlp_pkg::cfg_t    regs;
        tlp_pkg::result_t placements_due[$];
        int unsigned      errors;

        function new();
            regs   = '0;
            errors = 0;
        endfunction

        function void store_reg(logic [tlp_pkg::REG_INDEX_W-1:0] index,
                                logic [tlp_pkg::REG_DATA_W-1:0]  data);
            case (index)
                tlp_pkg::REG_VIDEO_CONTROL:  regs.video_control   = data;
                tlp_pkg::REG_SCROLL_X_P0:    regs.scroll_x_plane0 = data;
                tlp_pkg::REG_SCROLL_Y_P0:    regs.scroll_y_plane0 = data;
                tlp_pkg::REG_SCROLL_X_P1:    regs.scroll_x_plane1 = data;
                tlp_pkg::REG_SCROLL_Y_P1:    regs.scroll_y_plane1 = data;
                tlp_pkg::REG_BANK_NIBBLES:   regs.bank_nibbles    = data;
                tlp_pkg::REG_CUSTOM_BANKING: regs.custom_banking  = data[0];
                default:                     ;
            endcase
        endfunction

        function tlp_pkg::result_t place_tile(tlp_pkg::item_t t);
            tlp_pkg::result_t r;
            logic        plane;
            logic        flip_x;
            logic        flip_y;
            logic [15:0] code;
            logic [8:0]  scroll_x;
            logic [8:0]  scroll_y;
            logic [8:0]  cell_x;
            logic [8:0]  cell_y;
            logic [8:0]  wrap_x;
            logic [8:0]  wrap_y;
            int          pos_x;
            int          pos_y;
            logic [1:0]  bank;
            logic [3:0]  mapped_bank;

            flip_y   = regs.video_control[tlp_pkg::VC_FLIP_Y];
            flip_x   = regs.video_control[tlp_pkg::VC_FLIP_X];
            plane    = regs.video_control[tlp_pkg::VC_PLANE_ORDER] ^ t.opaque_pass;
            code     = plane ? t.code_plane1 : t.code_plane0;
            scroll_x = plane ? regs.scroll_x_plane1[8:0] : regs.scroll_x_plane0[8:0];
            scroll_y = plane ? regs.scroll_y_plane1[8:0] : regs.scroll_y_plane0[8:0];
            cell_x   = {t.tile_index[5:0], 3'b000};
            cell_y   = {t.tile_index[11:6], 3'b000};

            // screen flips mirror the cell about 63*8 and the scroll too
            if (flip_x)
            begin
                scroll_x = 9'd192 - scroll_x;
                cell_x   = 9'd504 - cell_x;
            end
            if (flip_y)
            begin
                scroll_y = 9'd256 - scroll_y;
                cell_y   = 9'd504 - cell_y;
            end

            wrap_x = cell_x - scroll_x;
            wrap_y = cell_y - scroll_y;
            pos_x  = (wrap_x >= 9'd320) ? int'(wrap_x) - 512 : int'(wrap_x);
            pos_y  = (wrap_y >= 9'd256) ? int'(wrap_y) - 512 : int'(wrap_y);

            bank        = code[12:11];
            mapped_bank = regs.custom_banking ? regs.bank_nibbles[4*bank +: 4]
                                              : {2'b00, bank};

            r.visible      = (pos_x > -8) && (pos_y > 8) && (pos_x < 320) && (pos_y < 240);
            r.screen_x     = pos_x[9:0];
            r.screen_y     = pos_y[8:0];
            r.gfx_address  = {mapped_bank, code[10:0], 4'b0000};
            r.colour_group = {2'b10, plane, code[15:13]};
            r.plane_used   = plane;
            r.mirror_x     = flip_x;
            r.mirror_y     = regs.video_control[tlp_pkg::VC_TILE_FLIP_Y] ^ flip_y;
            r.transparent  = ~t.opaque_pass;
            return r;
        endfunction

        function void note_tile(tlp_pkg::item_t t);
            placements_due.push_back(place_tile(t));
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [tlp_pkg::OUT_TDATA_W-1:0] data, logic user);
            tlp_pkg::result_t want;
            if (placements_due.size() == 0)
            begin
                $error("result item with no tile pending: tdata 0x%0h", data);
                errors++;
                return;
            end
            want = placements_due.pop_front();
            check_field("visible",      32'(want.visible),      32'(data[0]));
            check_field("screen_x",     32'($unsigned(want.screen_x)), 32'(data[10:1]));
            check_field("screen_y",     32'($unsigned(want.screen_y)), 32'(data[19:11]));
            check_field("gfx_address",  32'(want.gfx_address),  32'(data[38:20]));
            check_field("colour_group", 32'(want.colour_group), 32'(data[44:39]));
            check_field("plane_used",   32'(want.plane_used),   32'(user));
            check_field("mirror_x",     32'(want.mirror_x),     32'(data[45]));
            check_field("mirror_y",     32'(want.mirror_y),     32'(data[46]));
            check_field("transparent",  32'(want.transparent),  32'(data[47]));
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n         = 1'b0;
    logic                            cfg_wen       = 1'b0;
    logic [tlp_pkg::REG_INDEX_W-1:0] cfg_index     = '0;
    logic [tlp_pkg::REG_DATA_W-1:0]  cfg_data      = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [tlp_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [tlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;

    placement_scoreboard sb = new();
    bit                  quiet        = 1'b0;
    bit                  hold_pending = 1'b0;
    int unsigned         cycle_count  = 0;
    tlp_pkg::item_t      directed_tiles [DIRECTED_TILES];

    tile_layer_placement u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // observers: sampled at the edge, before any driver update lands
    always @(posedge clk)
    begin
        if (rst_n && cfg_wen)
            sb.store_reg(cfg_index, cfg_data);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_tile(tlp_pkg::item_t'{s_axis_tdata[11:0], s_axis_tdata[27:12],
                                          s_axis_tdata[43:28], s_axis_tuser});
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // receiver: random stalls, one long hold-off on request, none when quiet
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[tile_layer_placement] ERROR");
        $finish;
    end

    function automatic tlp_pkg::item_t make_tile(logic [11:0] index, logic [15:0] code0,
                                                 logic [15:0] code1, logic opaque);
        return tlp_pkg::item_t'{index, code0, code1, opaque};
    endfunction

    function automatic logic [15:0] pick_setting();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_tile(input tlp_pkg::item_t t);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {16'($urandom), 32'($urandom)};
            s_axis_tuser  <= 1'($urandom);
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, t.code_plane1, t.code_plane0, t.tile_index};
        s_axis_tuser  <= t.opaque_pass;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // lower tvalid and wait until every placement has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.placements_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] values [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= tlp_pkg::REG_INDEX_W'(i);
            cfg_data  <= values[i];
            @(posedge clk);
        end
        // writes past the last register must be dropped
        cfg_index <= REG_UNUSED;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_directed();
        foreach (directed_tiles[i])
            send_tile(directed_tiles[i]);
        drain();
    endtask

    initial
    begin
        logic [15:0] setting [NUM_REGS];

        // window edges with zero scroll: columns 39/40, rows 1/2 and 29/30
        directed_tiles[0] = make_tile(12'd0,    16'h0000, 16'hffff, 1'b0);
        directed_tiles[1] = make_tile(12'd4095, 16'hffff, 16'h0000, 1'b1);
        directed_tiles[2] = make_tile(12'd167,  16'h5a5a, 16'ha5a5, 1'b0);
        directed_tiles[3] = make_tile(12'd1896, 16'h1800, 16'h0800, 1'b1);
        directed_tiles[4] = make_tile(12'd64,   16'h07ff, 16'he000, 1'b0);
        directed_tiles[5] = make_tile(12'd1920, 16'h1000, 16'h2fff, 1'b1);
        directed_tiles[6] = make_tile(12'd63,   16'h0800, 16'h1800, 1'b1);
        directed_tiles[7] = make_tile(12'd4032, 16'hc3c3, 16'h3c3c, 1'b0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers as reset
        send_directed();

        // both screen flips, plane order, tile flip, wide scrolls, custom banks
        setting = '{16'h002b, 16'hffff, 16'h8000, 16'h01ff, 16'h0100, 16'hfedc, 16'hffff};
        program_regs(setting);
        send_directed();

        // screen flip y alone against tile flip y, direct banks
        setting = '{16'h0021, 16'h0140, 16'h00f8, 16'h7e07, 16'h0009, 16'h3210, 16'h0000};
        program_regs(setting);
        send_directed();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                setting[i] = (phase == 0) ? 16'h0000 :
                             (phase == 1) ? 16'hffff : pick_setting();
            program_regs(setting);
            if (phase == 3)
                hold_pending = 1'b1;
            if (phase == RANDOM_PHASES - 1)
                quiet = 1'b1;
            for (int n = 0; n < TILES_PER_PHASE; n++)
                send_tile(make_tile(12'($urandom), 16'($urandom), 16'($urandom),
                                    1'($urandom)));
            drain();
        end

        // catch any stray result after the last one
        repeat (6) @(posedge clk);
        if (sb.errors == 0 && sb.placements_due.size() == 0)
            $display("[tile_layer_placement] OK");
        else
            $display("[tile_layer_placement] ERROR");
        $finish;
    end

endmodule
